// ----- src/dla_pkg.sv -----
package dla_pkg;

	localparam int MAX_LEASES = 64;
	localparam int CNT_W      = $clog2(MAX_LEASES + 1);
	localparam int IDX_W      = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [7:0] MSG_DISCOVER = 8'd1;
	localparam logic [7:0] MSG_REQUEST  = 8'd3;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_OFFER = 2'd1;
	localparam logic [1:0] KIND_ACK   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_END   = 2'd1;

	typedef struct packed {
		logic [7:0]  msg_type;
		logic [47:0] client_mac;
		logic [31:0] transaction_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [31:0] client_ip;
		logic [31:0] reply_xid;
		logic [47:0] reply_mac;
	} rsp_t;

	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] ip;
	} lease_t;

	localparam int LEASE_W = $bits(lease_t);

	typedef struct packed {
		logic [31:0] first;
		logic [31:0] last;
	} pool_cfg_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		lease_t           wdata;
		logic [IDX_W-1:0] raddr;
	} ram_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_DONE
	} st_t;

endpackage

// ----- src/dla_ram.sv -----
module dla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/dla_ctrl.sv -----
module dla_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  dla_pkg::req_t       req,
	input  logic                req_valid,
	output logic                req_stall,
	input  dla_pkg::pool_cfg_t  pool,
	output dla_pkg::ram_cmd_t   ram_cmd,
	input  dla_pkg::lease_t     ram_rdata,
	output dla_pkg::rsp_t       res,
	output logic                res_valid,
	input  logic                res_take
);
	import dla_pkg::*;

	st_t              state_q, state_d;
	req_t             req_q;
	logic [CNT_W-1:0] idx_q;
	logic             rd_vld_s1;
	logic             found_q;
	logic [31:0]      hit_ip_q;
	logic [CNT_W-1:0] count_q;
	logic [32:0]      next_q;
	logic             loaded_q;
	rsp_t             res_q;

	logic        accept;
	logic        skip_scan;
	logic        last_idx;
	logic        is_disc, is_req;
	logic [32:0] base;
	logic        room, fits, load_ptr, alloc;
	rsp_t        res_d;

	assign accept    = req_valid && !req_stall;
	assign skip_scan = (count_q == '0) ||
		((req.msg_type != MSG_DISCOVER) && (req.msg_type != MSG_REQUEST));
	assign last_idx  = (idx_q == count_q - CNT_W'(1));

	assign is_disc  = (req_q.msg_type == MSG_DISCOVER);
	assign is_req   = (req_q.msg_type == MSG_REQUEST);
	assign base     = loaded_q ? next_q : {1'b0, pool.first};
	assign room     = (count_q < CNT_W'(MAX_LEASES));
	assign fits     = (base <= {1'b0, pool.last});
	assign load_ptr = is_disc && !found_q && room;
	assign alloc    = load_ptr && fits;

	always_comb begin
		res_d = '0;
		if (is_disc && found_q) begin
			res_d.reply_kind = KIND_OFFER;
			res_d.client_ip  = hit_ip_q;
		end else if (alloc) begin
			res_d.reply_kind = KIND_OFFER;
			res_d.client_ip  = base[31:0];
		end else if (is_req && found_q) begin
			res_d.reply_kind = KIND_ACK;
			res_d.client_ip  = hit_ip_q;
		end
		if (res_d.reply_kind != KIND_NONE) begin
			res_d.reply_xid = req_q.transaction_id;
			res_d.reply_mac = req_q.client_mac;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = skip_scan ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall     = 1'b1;
		res_valid     = 1'b0;
		ram_cmd.we    = 1'b0;
		ram_cmd.waddr = count_q[IDX_W-1:0];
		ram_cmd.wdata = '{mac: req_q.client_mac, ip: base[31:0]};
		ram_cmd.raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE:   req_stall  = 1'b0;
			ST_SCAN:   ;
			ST_DRAIN:  ;
			ST_DECIDE: ram_cmd.we = alloc;
			ST_DONE:   res_valid  = 1'b1;
			default:   ;
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
			next_q    <= '0;
			loaded_q  <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				found_q <= 1'b0;
			end else if (rd_vld_s1 && !found_q && (ram_rdata.mac == req_q.client_mac)) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_DECIDE && load_ptr) begin
				loaded_q <= 1'b1;
				next_q   <= alloc ? base + 33'd1 : base;
				if (alloc) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			idx_q <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (rd_vld_s1 && !found_q) begin
			hit_ip_q <= ram_rdata.ip;
		end
		if (state_q == ST_DECIDE) begin
			res_q <= res_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEASES))
		else $error("lease count past table size");

	a_write_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		ram_cmd.we |-> (state_q == ST_DECIDE) && room && !found_q)
		else $error("table write outside allocation");

	a_ptr_up: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q && $past(loaded_q) |-> next_q >= $past(next_q))
		else $error("address pointer moved down");

	a_read_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
		else $error("table read in flight outside scan");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DECIDE) |=> count_q == $past(count_q))
		else $error("lease count changed outside decision");

endmodule

// ----- src/dhcp_lease_allocator.sv -----
// channel   dir  payload  handshake                 accepted when
// req       in   req_t    req_valid / req_stall     req_valid && !req_stall
// rsp       out  rsp_t    rsp_valid / rsp_stall     rsp_valid && !rsp_stall
// cfg       in   32 bit   cfg_we, cfg_index         cfg_we
//
// A request of an ignored type, or any request while the table is empty,
// skips the lease memory scan; otherwise the block scans the lease memory at
// one entry per cycle.
// One request is in work at a time; a finished reply waits in the output
// register while the next request is taken.
// Reset empties the table by zeroing the entry count, and clears the pointer and both pool registers; no clearing pass.
// rsp_stall holds the reply in place; the block keeps working until it has a
// second reply to hand over.
module dhcp_lease_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dla_pkg::req_t                      req,
	input  logic                               req_valid,
	output logic                               req_stall,
	output dla_pkg::rsp_t                      rsp,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	input  logic                               cfg_we,
	input  logic [dla_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dla_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dla_pkg::*;

	pool_cfg_t pool_q;
	ram_cmd_t  ram_cmd;
	lease_t    ram_rdata;
	logic [LEASE_W-1:0] ram_rdata_raw;
	rsp_t      res;
	logic      res_valid;
	logic      res_take;
	logic      out_valid_q;
	rsp_t      out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POOL_START: pool_q.first <= cfg_data;
				REG_POOL_END:   pool_q.last  <= cfg_data;
				default:        ;
			endcase
		end
	end

	dla_ram #(
		.WIDTH(LEASE_W),
		.DEPTH(MAX_LEASES)
	) u_lease_ram (
		.clk  (clk),
		.we   (ram_cmd.we),
		.waddr(ram_cmd.waddr),
		.wdata(ram_cmd.wdata),
		.raddr(ram_cmd.raddr),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = lease_t'(ram_rdata_raw);

	dla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.pool     (pool_q),
		.ram_cmd  (ram_cmd),
		.ram_rdata(ram_rdata),
		.res      (res),
		.res_valid(res_valid),
		.res_take (res_take)
	);

	assign res_take = res_valid && (!out_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

endmodule

// ----- bench/dhcp_lease_allocator_tb.sv -----
module dhcp_lease_allocator_tb;
	import dla_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 105;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [47:0] MAC_A    = 48'h02_00_5E_10_00_01;
	localparam logic [47:0] MAC_C    = 48'h80_00_00_00_00_00;
	localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
	localparam rsp_t        NO_REPLY = '0;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		req_t                  req;
		logic                  typed;
		rsp_t                  want;
	} plan_row_t;

	localparam int PLAN_LEN = 23;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_REQ, REG_POOL_START, 32'd0, '{8'h00, 48'd0, 32'd0}, 1'b1, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{8'hFF, MAC_ONES, 32'hFFFF_FFFF}, 1'b1, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{8'h02, MAC_A, 32'h0000_0100}, 1'b1, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{8'h81, MAC_A, 32'h0000_0101}, 1'b1, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_REQUEST, MAC_A, 32'h0000_0102}, 1'b1, NO_REPLY},
		'{ROW_CFG, REG_POOL_START, 32'h0A00_0010, '0, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_DISCOVER, MAC_A, 32'h0000_0103}, 1'b1, NO_REPLY},
		'{ROW_CFG, REG_POOL_END, 32'h0A00_0012, '0, 1'b0, NO_REPLY},
		'{ROW_CFG, REG_POOL_START, 32'hFFFF_FFFF, '0, 1'b0, NO_REPLY},
		'{ROW_CFG, REG_SPARE_2, 32'h0A00_0000, '0, 1'b0, NO_REPLY},
		'{ROW_CFG, REG_SPARE_3, 32'h0000_0000, '0, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_DISCOVER, MAC_A, 32'h0000_0001}, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_DISCOVER, MAC_ONES, 32'hFFFF_FFFF}, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_DISCOVER, MAC_A, 32'h0000_0002}, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_REQUEST, MAC_ONES, 32'h0000_0000}, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_DISCOVER, 48'd0, 32'h8000_0000}, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_DISCOVER, MAC_C, 32'h0000_0004}, 1'b1, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_REQUEST, MAC_C, 32'h0000_0005}, 1'b1, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{8'h83, MAC_A, 32'h0000_0006}, 1'b1, NO_REPLY},
		'{ROW_CFG, REG_POOL_END, 32'hFFFF_FFFF, '0, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_DISCOVER, MAC_C, 32'h0000_0007}, 1'b0, NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_REQUEST, MAC_A ^ 48'd1, 32'h0000_0008}, 1'b1,
			NO_REPLY},
		'{ROW_REQ, REG_POOL_START, 32'd0, '{MSG_REQUEST, MAC_A, 32'h0000_0009}, 1'b0, NO_REPLY}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	req_t                  req = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	rsp_t                  rsp;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit calm = 1'b0;
	int bad_fields = 0;
	int cycles = 0;
	rsp_t lease_replies_due[$];

	logic [31:0] pool_first = '0;
	logic [31:0] pool_last = '0;
	bit          held [MAX_LEASES];
	logic [47:0] held_mac [MAX_LEASES];
	logic [31:0] held_ip [MAX_LEASES];
	int          held_count = 0;
	logic [32:0] next_free = '0;
	bit          next_free_loaded = 1'b0;

	dhcp_lease_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(0, 99) < 30);
	end

	function automatic rsp_t lease_reply(input req_t r);
		rsp_t        o;
		int          i;
		int          slot;
		bit          found;
		bit          placed;
		logic [31:0] ip;
		o = '0;
		slot = -1;
		found = 1'b0;
		placed = 1'b0;
		ip = '0;
		for (i = 0; i < MAX_LEASES; i++) begin
			if (slot < 0 && held[i] && held_mac[i] == r.client_mac) begin
				slot = i;
			end
		end
		if (r.msg_type == MSG_DISCOVER) begin
			if (slot >= 0) begin
				o.reply_kind = KIND_OFFER;
				ip = held_ip[slot];
			end else if (held_count < MAX_LEASES) begin
				if (!next_free_loaded) begin
					next_free = {1'b0, pool_first};
					next_free_loaded = 1'b1;
				end
				while (!found && next_free <= {1'b0, pool_last}) begin
					ip = next_free[31:0];
					next_free = next_free + 33'd1;
					found = 1'b1;
					for (i = 0; i < MAX_LEASES; i++) begin
						if (held[i] && held_ip[i] == ip) begin
							found = 1'b0;
						end
					end
				end
				if (found) begin
					for (i = 0; i < MAX_LEASES; i++) begin
						if (!placed && !held[i]) begin
							held[i] = 1'b1;
							held_mac[i] = r.client_mac;
							held_ip[i] = ip;
							placed = 1'b1;
						end
					end
					held_count++;
					o.reply_kind = KIND_OFFER;
				end
			end
		end else if (r.msg_type == MSG_REQUEST && slot >= 0) begin
			o.reply_kind = KIND_ACK;
			ip = held_ip[slot];
		end
		if (o.reply_kind != KIND_NONE) begin
			o.client_ip = ip;
			o.reply_xid = r.transaction_id;
			o.reply_mac = r.client_mac;
		end
		return o;
	endfunction

	task automatic flag_reply(input string what);
		bad_fields++;
		if (bad_fields <= 100) begin
			$display("%0t reply mismatch: %s", $time, what);
		end
	endtask

	task automatic send_request(input req_t r, input logic typed, input rsp_t want);
		rsp_t reply;
		while (!calm && $urandom_range(0, 99) < 30) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		reply = lease_reply(r);
		lease_replies_due.push_back(typed ? want : reply);
	endtask

	// block is idle once every request has its reply
	task automatic write_pool_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		req_valid <= 1'b0;
		do @(posedge clk); while (lease_replies_due.size() != 0);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POOL_START) begin
			pool_first = val;
		end else if (idx == REG_POOL_END) begin
			pool_last = val;
		end
	endtask

	always @(posedge clk) begin : reply_check
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (lease_replies_due.size() == 0) begin
				flag_reply($sformatf("unexpected reply kind %0d ip %h mac %h",
					rsp.reply_kind, rsp.client_ip, rsp.reply_mac));
			end else begin
				want = lease_replies_due.pop_front();
				if (rsp.reply_kind !== want.reply_kind) begin
					flag_reply($sformatf("reply_kind %0d, want %0d",
						rsp.reply_kind, want.reply_kind));
				end
				if (rsp.client_ip !== want.client_ip) begin
					flag_reply($sformatf("client_ip %h, want %h", rsp.client_ip, want.client_ip));
				end
				if (rsp.reply_xid !== want.reply_xid) begin
					flag_reply($sformatf("reply_xid %h, want %h", rsp.reply_xid, want.reply_xid));
				end
				if (rsp.reply_mac !== want.reply_mac) begin
					flag_reply($sformatf("reply_mac %h, want %h", rsp.reply_mac, want.reply_mac));
				end
			end
		end
	end

	initial begin
		int          row;
		int          phase;
		int          n;
		int          pick;
		req_t        r;
		logic [63:0] wide;
		logic [31:0] pool_top;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < PLAN_LEN; row++) begin
			if (PLAN[row].kind == ROW_CFG) begin
				write_pool_reg(PLAN[row].reg_idx, PLAN[row].reg_val);
			end else begin
				send_request(PLAN[row].req, PLAN[row].typed, PLAN[row].want);
			end
		end

		for (phase = 0; phase < PHASES; phase++) begin
			// pointer is already loaded, so pool_start must not matter
			write_pool_reg(REG_POOL_START, $urandom);
			case (phase)
				1: begin
					pool_top = next_free[31:0] - 32'd5;
				end
				4, 5: begin
					pool_top = 32'hFFFF_FFFF;
				end
				default: begin
					pool_top = next_free[31:0] + $urandom_range(6, 20);
				end
			endcase
			write_pool_reg(REG_POOL_END, pool_top);
			calm = (phase == 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				wide = {$urandom, $urandom};
				r.client_mac = wide[47:0];
				r.transaction_id = $urandom;
				pick = $urandom_range(0, 99);
				if (pick >= 25 && pick < 90 && held_count != 0) begin
					r.client_mac = held_mac[$urandom_range(0, held_count - 1)];
					if (pick >= 85) begin
						r.client_mac = r.client_mac ^ (48'd1 << $urandom_range(0, 47));
					end
				end
				if (pick < 55) begin
					r.msg_type = MSG_DISCOVER;
				end else if (pick < 85) begin
					r.msg_type = MSG_REQUEST;
				end else if (pick < 90) begin
					r.msg_type = pick[0] ? MSG_DISCOVER : MSG_REQUEST;
				end else begin
					r.msg_type = 8'($urandom_range(0, 255));
				end
				send_request(r, 1'b0, NO_REPLY);
			end
		end
		calm = 1'b0;

		req_valid <= 1'b0;
		while (lease_replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_fields == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
